FILE: rtl/strand_base_coverage_ring_top_macros.svh
// ------------------------------------------------------------------------
// strand base coverage ring assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ------------------------------------------------------------------------
`ifndef STRAND_BASE_COVERAGE_RING_TOP_MACROS_SVH
`define STRAND_BASE_COVERAGE_RING_TOP_MACROS_SVH

// property must hold at every edge out of reset
`define SBCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define SBCR_NEVER(lbl, cond, msg) \
    `SBCR_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/sbcr_pkg.sv
// ------------------------------------------------------------------------
// sbcr_pkg
// types, codes and sizes shared by the coverage ring modules
// ------------------------------------------------------------------------
package sbcr_pkg;

    localparam int BUF_DEPTH  = 4096;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DEPTH_BITS = 24;
    localparam int POS_W      = 31;
    localparam int LEN_W      = 28;
    localparam int CONTIG_W   = 16;
    localparam int START_W    = 32;

    localparam logic [POS_W-1:0]      POS_MAX   = '1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_CIGAR = 2'd1,
        REQ_DRAIN = 2'd2,
        REQ_FLUSH = 2'd3
    } t_req;

    typedef logic [1:0] t_op;
    localparam t_op OP_COVER = 2'd0;
    localparam t_op OP_DEL   = 2'd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_ORDER    = 3'd2,
        ST_BUSY     = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_DRN_WR, S_CHECK, S_WALK, S_WALK_WR, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        C_NONE, C_CLR, C_LATCH, C_BUSY, C_DRN_RD, C_DRN_WR, C_BEGIN, C_FLUSH,
        C_NOREAD, C_NEWEND, C_BAD, C_RUN_SET, C_DEL_ARM, C_WALK_RD, C_WALK_WR,
        C_DEL_SKIP, C_FINISH, C_EMIT
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic pending_nz;
        logic read_open;
        logic run_empty;
        logic del_pend;
        logic bad;
        logic out_free;
        t_req req;
        t_op  op_kind;
        logic last_op;
    } t_dp_stat;

endpackage

FILE: rtl/sbcr_ram.sv
// ------------------------------------------------------------------------
// sbcr_ram
// generic single write port, single read port ram with registered read
// ------------------------------------------------------------------------
module sbcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/sbcr_ctrl.sv
// ------------------------------------------------------------------------
// sbcr_ctrl
// sequencer: store clear, request decode, run walk, drain and result hand-off
// ------------------------------------------------------------------------
module sbcr_ctrl
    import sbcr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_cmd     o_cmd
);
    t_state r_state, n_state;

    logic covers;
    assign covers = (i_stat.op_kind == OP_COVER) || (i_stat.op_kind == OP_DEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (i_stat.req == REQ_DRAIN) begin
                    n_state = i_stat.pending_nz ? S_DRN_WR : S_DONE;
                end else if (i_stat.pending_nz || i_stat.req != REQ_CIGAR
                             || !i_stat.read_open) begin
                    n_state = S_DONE;
                end else if (covers) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = i_stat.last_op ? S_WALK : S_DONE;
                end
            end
            S_CHECK: begin
                if (i_stat.bad) begin
                    n_state = S_DONE;
                end else if (i_stat.op_kind == OP_DEL) begin
                    n_state = S_WALK;
                end else begin
                    n_state = i_stat.last_op ? S_WALK : S_DONE;
                end
            end
            S_WALK: begin
                if (!i_stat.run_empty) begin
                    n_state = S_WALK_WR;
                end else if (i_stat.del_pend) begin
                    n_state = i_stat.last_op ? S_WALK : S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK_WR: n_state = S_WALK;
            S_DRN_WR:  n_state = S_DONE;
            S_DONE:    if (i_stat.out_free) n_state = S_IDLE;
            default:   n_state = S_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = C_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd = C_CLR;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = C_LATCH;
            end
            S_DECODE: begin
                if (i_stat.req == REQ_DRAIN) begin
                    if (i_stat.pending_nz) o_cmd = C_DRN_RD;
                end else if (i_stat.pending_nz) begin
                    o_cmd = C_BUSY;
                end else if (i_stat.req == REQ_BEGIN) begin
                    o_cmd = C_BEGIN;
                end else if (i_stat.req == REQ_FLUSH) begin
                    o_cmd = C_FLUSH;
                end else if (!i_stat.read_open) begin
                    o_cmd = C_NOREAD;
                end else if (covers) begin
                    o_cmd = C_NEWEND;
                end
            end
            S_CHECK: begin
                if (i_stat.bad) begin
                    o_cmd = C_BAD;
                end else if (i_stat.op_kind == OP_DEL) begin
                    o_cmd = C_DEL_ARM;
                end else begin
                    o_cmd = C_RUN_SET;
                end
            end
            S_WALK: begin
                if (!i_stat.run_empty) begin
                    o_cmd = C_WALK_RD;
                end else if (i_stat.del_pend) begin
                    o_cmd = C_DEL_SKIP;
                end else begin
                    o_cmd = C_FINISH;
                end
            end
            S_WALK_WR: o_cmd = C_WALK_WR;
            S_DRN_WR:  o_cmd = C_DRN_WR;
            S_DONE:    if (i_stat.out_free) o_cmd = C_EMIT;
            default:   o_cmd = C_NONE;
        endcase
    end
endmodule

FILE: rtl/sbcr_dp.sv
// ------------------------------------------------------------------------
// sbcr_dp
// window registers, depth stores and result register of the coverage ring
// ------------------------------------------------------------------------
module sbcr_dp
    import sbcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_req                  i_req,
    input  logic [CONTIG_W-1:0]   i_contig_index,
    input  logic [START_W-1:0]    i_read_start,
    input  logic [POS_W-1:0]      i_contig_length,
    input  logic                  i_reverse_strand,
    input  t_op                   i_op_kind,
    input  logic [LEN_W-1:0]      i_op_length,
    input  logic                  i_last_op,
    input  logic                  i_out_ready,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    output t_status               o_status,
    output logic [POS_W-1:0]      o_read_end,
    output logic [CNT_W-1:0]      o_pending_count,
    output logic                  o_position_valid,
    output logic [POS_W-1:0]      o_position,
    output logic [DEPTH_BITS-1:0] o_forward_depth,
    output logic [DEPTH_BITS-1:0] o_reverse_depth
);
    // latched request
    t_req                r_req;
    logic [CONTIG_W-1:0] r_contig;
    logic [START_W-1:0]  r_start;
    logic [POS_W-1:0]    r_clen;
    logic                r_rev;
    t_op                 r_kind;
    logic [LEN_W-1:0]    r_len;
    logic                r_last;

    // window state
    logic [ADDR_W-1:0]   r_head;
    logic [CNT_W-1:0]    r_tail, r_wc, r_dl;
    logic [POS_W-1:0]    r_ls, r_le, r_rs, r_re;
    logic [CONTIG_W-1:0] r_cc;
    logic                r_pend, r_strand, r_open, r_del;
    logic [POS_W:0]      r_newend;
    logic [ADDR_W-1:0]   r_clr;

    // result of current request
    t_status             r_st;
    logic [POS_W-1:0]    r_rend, r_pos;
    logic                r_pv;
    logic [DEPTH_BITS-1:0] r_fd, r_rd;

    // output register
    logic                r_ov;
    t_status             r_o_st;
    logic [POS_W-1:0]    r_o_rend, r_o_pos;
    logic [CNT_W-1:0]    r_o_pc;
    logic                r_o_pv;
    logic [DEPTH_BITS-1:0] r_o_fd, r_o_rd;

    // stores
    logic                  fwd_we, rev_we;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [DEPTH_BITS-1:0] fwd_wd, rev_wd, fwd_q, rev_q, sel_q, inc_q;

    sbcr_ram #(.WIDTH(DEPTH_BITS), .DEPTH(BUF_DEPTH)) u_fwd (
        .i_clk(i_clk), .i_we(fwd_we), .i_waddr(waddr), .i_wdata(fwd_wd),
        .i_raddr(raddr), .o_rdata(fwd_q)
    );
    sbcr_ram #(.WIDTH(DEPTH_BITS), .DEPTH(BUF_DEPTH)) u_rev (
        .i_clk(i_clk), .i_we(rev_we), .i_waddr(waddr), .i_wdata(rev_wd),
        .i_raddr(raddr), .o_rdata(rev_q)
    );

    assign sel_q = r_strand ? rev_q : fwd_q;
    assign inc_q = (sel_q == DEPTH_MAX) ? sel_q : sel_q + 1'b1;

    always_comb begin
        fwd_we = 1'b0;
        rev_we = 1'b0;
        waddr  = r_wc[ADDR_W-1:0];
        fwd_wd = '0;
        rev_wd = '0;
        raddr  = (i_cmd == C_DRN_RD) ? r_head : r_wc[ADDR_W-1:0];
        case (i_cmd)
            C_CLR: begin
                fwd_we = 1'b1;
                rev_we = 1'b1;
                waddr  = r_clr;
            end
            C_DRN_WR: begin
                fwd_we = 1'b1;
                rev_we = 1'b1;
                waddr  = r_head;
            end
            C_WALK_WR: begin
                fwd_we = !r_strand;
                rev_we = r_strand;
                fwd_wd = inc_q;
                rev_wd = inc_q;
            end
            default: ;
        endcase
    end

    // commit of an open read's written runs
    logic             commit;
    logic [POS_W-1:0] le_a;
    logic [CNT_W-1:0] tail_a, win_a;
    assign commit = r_open && (r_rs > r_le);
    assign le_a   = commit ? r_rs : r_le;
    assign tail_a = commit ? r_wc : r_tail;
    assign win_a  = (tail_a > {1'b0, r_head}) ? tail_a - {1'b0, r_head} : '0;

    // read begin decisions
    logic             ooo, ign, all_w;
    logic [POS_W-1:0] srt;
    logic [CNT_W-1:0] dl_begin;
    assign ooo = (r_contig < r_cc) || ((r_contig == r_cc) &&
                 ($signed({r_start[START_W-1], r_start}) < $signed({2'b00, r_ls})));
    assign srt      = r_start[START_W-1] ? '0 : r_start[POS_W-1:0];
    assign ign      = srt >= r_clen;
    assign all_w    = (r_contig != r_cc) || (srt > le_a);
    assign dl_begin = all_w ? win_a : CNT_W'(srt - r_ls);

    // flush restart position
    logic [POS_W-1:0] rs_flush;
    assign rs_flush = (le_a < POS_MAX) ? le_a + 1'b1 : POS_MAX;

    // extent check of a covering or deletion op
    logic [POS_W+2:0] extent;
    logic             bad;
    assign extent = (POS_W+3)'(r_wc - {1'b0, r_head}) + (POS_W+3)'(r_newend - {1'b0, r_rs});
    assign bad    = (extent > (POS_W+3)'(BUF_DEPTH)) || (r_newend > {1'b0, POS_MAX});

    // drain step
    logic [ADDR_W-1:0] head_n;
    logic [CNT_W-1:0]  dl_n;
    logic [POS_W-1:0]  ls_n;
    assign head_n = r_head + 1'b1;
    assign dl_n   = r_dl - 1'b1;
    assign ls_n   = r_ls + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_LATCH) begin
            r_req    <= i_req;
            r_contig <= i_contig_index;
            r_start  <= i_read_start;
            r_clen   <= i_contig_length;
            r_rev    <= i_reverse_strand;
            r_kind   <= i_op_kind;
            r_len    <= i_op_length;
            r_last   <= i_last_op;
        end
        if (i_cmd == C_NEWEND) r_newend <= {1'b0, r_re} + (POS_W+1)'(r_len);
        if (i_cmd == C_EMIT) begin
            r_o_st   <= r_st;
            r_o_rend <= r_rend;
            r_o_pc   <= r_dl;
            r_o_pv   <= r_pv;
            r_o_pos  <= r_pos;
            r_o_fd   <= r_fd;
            r_o_rd   <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_wc <= '0; r_dl <= '0;
            r_ls <= '0; r_le <= '0; r_rs <= '0; r_re <= '0; r_cc <= '0;
            r_pend <= 1'b0; r_strand <= 1'b0; r_open <= 1'b0; r_del <= 1'b0;
            r_clr <= '0; r_ov <= 1'b0;
            r_st <= ST_OK; r_rend <= '0; r_pos <= '0; r_pv <= 1'b0;
            r_fd <= '0; r_rd <= '0;
        end else begin
            if (i_cmd == C_EMIT) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd)
                C_CLR: r_clr <= r_clr + 1'b1;
                C_LATCH: begin
                    r_st <= ST_OK; r_rend <= '0; r_pos <= '0; r_pv <= 1'b0;
                    r_fd <= '0; r_rd <= '0;
                end
                C_BUSY:   r_st <= ST_BUSY;
                C_NOREAD: r_st <= ST_IGNORED;
                C_DRN_WR: begin
                    r_pos  <= ls_n;
                    r_ls   <= ls_n;
                    r_pv   <= 1'b1;
                    r_fd   <= fwd_q;
                    r_rd   <= rev_q;
                    r_head <= head_n;
                    r_wc   <= {1'b0, head_n};
                    r_dl   <= dl_n;
                    if (r_head == '1) begin
                        r_tail <= (r_tail >= CNT_W'(BUF_DEPTH)) ?
                                  r_tail - CNT_W'(BUF_DEPTH) : '0;
                    end
                    if (dl_n == '0 && r_pend) begin
                        r_head <= '0; r_tail <= '0; r_wc <= '0;
                        r_ls <= r_rs; r_le <= r_rs; r_pend <= 1'b0;
                    end
                end
                C_BEGIN: begin
                    r_le   <= le_a;
                    r_tail <= tail_a;
                    r_open <= 1'b0;
                    if (ooo) begin
                        r_st <= ST_ORDER;
                    end else if (ign) begin
                        r_st <= ST_IGNORED;
                    end else begin
                        r_dl     <= dl_begin;
                        r_rs     <= srt;
                        r_re     <= srt;
                        r_strand <= r_rev;
                        r_open   <= 1'b1;
                        r_wc     <= {1'b0, r_head};
                        if (all_w) begin
                            r_cc   <= r_contig;
                            r_pend <= 1'b1;
                            if (dl_begin == '0) begin
                                r_head <= '0; r_tail <= '0; r_wc <= '0;
                                r_ls <= srt; r_le <= srt; r_pend <= 1'b0;
                            end
                        end
                    end
                end
                C_FLUSH: begin
                    r_le   <= le_a;
                    r_tail <= tail_a;
                    r_open <= 1'b0;
                    r_rs   <= rs_flush;
                    r_re   <= rs_flush;
                    r_dl   <= win_a;
                    r_pend <= 1'b1;
                    if (win_a == '0) begin
                        r_head <= '0; r_tail <= '0; r_wc <= '0;
                        r_ls <= rs_flush; r_le <= rs_flush; r_pend <= 1'b0;
                    end
                end
                C_BAD: begin
                    r_st   <= ST_TOO_LONG;
                    r_le   <= le_a;
                    r_tail <= tail_a;
                    r_open <= 1'b0;
                end
                C_RUN_SET: r_re  <= r_newend[POS_W-1:0];
                C_DEL_ARM: r_del <= 1'b1;
                C_WALK_WR: begin
                    r_wc <= r_wc + 1'b1;
                    r_rs <= r_rs + 1'b1;
                end
                C_DEL_SKIP: begin
                    r_del <= 1'b0;
                    r_wc  <= r_wc + CNT_W'(r_len);
                    r_rs  <= r_newend[POS_W-1:0];
                    r_re  <= r_newend[POS_W-1:0];
                end
                C_FINISH: begin
                    r_le   <= le_a;
                    r_tail <= tail_a;
                    r_rend <= r_re;
                    r_open <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.clr_last   = (r_clr == '1);
    assign o_stat.pending_nz = (r_dl != '0);
    assign o_stat.read_open  = r_open;
    assign o_stat.run_empty  = (r_rs == r_re);
    assign o_stat.del_pend   = r_del;
    assign o_stat.bad        = bad;
    assign o_stat.out_free   = !r_ov || i_out_ready;
    assign o_stat.req        = r_req;
    assign o_stat.op_kind    = r_kind;
    assign o_stat.last_op    = r_last;

    assign o_out_valid      = r_ov;
    assign o_status         = r_o_st;
    assign o_read_end       = r_o_rend;
    assign o_pending_count  = r_o_pc;
    assign o_position_valid = r_o_pv;
    assign o_position       = r_o_pos;
    assign o_forward_depth  = r_o_fd;
    assign o_reverse_depth  = r_o_rd;
endmodule

FILE: rtl/strand_base_coverage_ring_top.sv
// ------------------------------------------------------------------------
// strand_base_coverage_ring_top
// strand-separated per-base depth counter over a circular window of
// position-sorted alignments
// ------------------------------------------------------------------------
// channel   dir  tdata                                    tuser / tlast
// s_axis    in   contig, start, contig length, strand,    req type, op kind
//                op length                                / last op
// m_axis    out  read end, pending, position, depths      status, pos valid
//
// after reset the two depth stores are zeroed, one entry a cycle, and no
// request is taken until every entry is cleared
// a read begin, flush, busy answer, empty drain or non-closing non-covering
// op is answered from S_DECODE, a drain clears the oldest entry in
// S_DRN_WR and covering and deletion ops are checked in S_CHECK; a deletion
// or the closing op then writes the pending run, each covered position read
// in S_WALK and written back in S_WALK_WR, and closing ends with the commit
// results sit in an output register, so a new request is taken while the
// previous result waits on o_m_axis_tvalid
// ------------------------------------------------------------------------
`include "strand_base_coverage_ring_top_macros.svh"

module strand_base_coverage_ring_top
    import sbcr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // contig_index[15:0], read_start[47:16], contig_length[78:48],
    // reverse_strand[79], op_length[107:80], zero pad
    input  logic [111:0] i_s_axis_tdata,
    // req_type[1:0], op_kind[3:2]
    input  logic [3:0]   i_s_axis_tuser,
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // read_end[30:0], pending_count[43:31], position[74:44],
    // forward_depth[98:75], reverse_depth[122:99], zero pad
    output logic [127:0] o_m_axis_tdata,
    // status[2:0], position_valid[3]
    output logic [3:0]   o_m_axis_tuser
);
    t_cmd     cmd;
    t_dp_stat stat;

    t_status               status;
    logic [POS_W-1:0]      read_end, position;
    logic [CNT_W-1:0]      pending;
    logic                  pos_valid;
    logic [DEPTH_BITS-1:0] fwd_depth, rev_depth;

    // sequencer
    sbcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    // window state, stores, output register
    sbcr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_req            (t_req'(i_s_axis_tuser[1:0])),
        .i_contig_index   (i_s_axis_tdata[15:0]),
        .i_read_start     (i_s_axis_tdata[47:16]),
        .i_contig_length  (i_s_axis_tdata[78:48]),
        .i_reverse_strand (i_s_axis_tdata[79]),
        .i_op_kind        (i_s_axis_tuser[3:2]),
        .i_op_length      (i_s_axis_tdata[107:80]),
        .i_last_op        (i_s_axis_tlast),
        .i_out_ready      (i_m_axis_tready),
        .o_stat           (stat),
        .o_out_valid      (o_m_axis_tvalid),
        .o_status         (status),
        .o_read_end       (read_end),
        .o_pending_count  (pending),
        .o_position_valid (pos_valid),
        .o_position       (position),
        .o_forward_depth  (fwd_depth),
        .o_reverse_depth  (rev_depth)
    );

    // result packing, lowest field first
    assign o_m_axis_tdata = {5'd0, rev_depth, fwd_depth, position, pending, read_end};
    assign o_m_axis_tuser = {pos_valid, status};

    // no request taken while the stores are being zeroed
    `SBCR_NEVER(a_no_take_in_clear, (cmd == C_CLR) && o_s_axis_tready, "request taken during clear")
    // a retired position only comes with an ok status
    `SBCR_ASSERT(a_pos_ok, (o_m_axis_tvalid && pos_valid) |-> (status == ST_OK), "position with bad status")
    // a read end is only reported on a successful request
    `SBCR_ASSERT(a_end_ok, (o_m_axis_tvalid && read_end != '0) |-> (status == ST_OK), "read end with bad status")
    // pending never exceeds the window
    `SBCR_ASSERT(a_pending_max, o_m_axis_tvalid |-> (pending <= CNT_W'(BUF_DEPTH)), "pending beyond window")
endmodule

FILE: verif/tb_strand_base_coverage_ring_top.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_strand_base_coverage_ring_top
// checks the strand-separated depth counter against an in-bench model of
// the ring; requests are built ahead of time, predicted in order, then
// streamed with random idling on both sides and compared field by field
// ------------------------------------------------------------------------
module tb_strand_base_coverage_ring_top;
    import sbcr_pkg::*;

    localparam int N_RANDOM = 1850;

    // one request as the sender sees it
    typedef struct {
        t_req             req;
        logic [15:0]      contig;
        logic [31:0]      start;
        logic [30:0]      clen;
        logic             rev;
        t_op              kind;
        logic [27:0]      len;
        logic             last;
    } t_request;

    // one result as the receiver sees it
    typedef struct packed {
        t_status          status;
        logic [30:0]      read_end;
        logic [12:0]      pending;
        logic             pos_valid;
        logic [30:0]      position;
        logic [23:0]      fwd;
        logic [23:0]      rev;
    } t_coverage;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [111:0] s_data = '0;
    logic [3:0]   s_user = '0;
    logic         s_last = 1'b0;
    logic         m_ready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [127:0] o_m_axis_tdata;
    logic [3:0]   o_m_axis_tuser;

    strand_base_coverage_ring_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    t_request  request_q[$];
    t_coverage coverage_q[$];
    int        n_total = 0;
    int        n_taken = 0;
    int        n_errors = 0;

    // ---------------------------------------------------------------
    // depth ring model
    // ---------------------------------------------------------------
    logic [23:0] fwd_cnt[BUF_DEPTH];
    logic [23:0] rev_cnt[BUF_DEPTH];
    int unsigned head, tail, win_lo, win_hi, cur_ctg, cursor, seg_lo, seg_hi, pend;
    bit          rebase_due, strand, open_read;

    // add the pending covered run to the store of the read's strand
    function automatic void paint_run();
        int unsigned n, idx;
        n = seg_hi - seg_lo;
        for (int unsigned i = 0; i < n; i++) begin
            idx = cursor % BUF_DEPTH;
            if (strand) begin
                if (rev_cnt[idx] != DEPTH_MAX) rev_cnt[idx]++;
            end else begin
                if (fwd_cnt[idx] != DEPTH_MAX) fwd_cnt[idx]++;
            end
            cursor++;
        end
        seg_lo = seg_hi;
    endfunction

    function automatic void close_end();
        if (seg_lo > win_hi) begin
            win_hi = seg_lo;
            tail = cursor;
        end
    endfunction

    function automatic void drop_read();
        if (open_read) close_end();
        open_read = 0;
    endfunction

    function automatic void restart_ring();
        head = 0;
        tail = 0;
        cursor = 0;
        win_lo = seg_lo;
        win_hi = seg_lo;
        rebase_due = 0;
    endfunction

    function automatic t_coverage predict_coverage(t_request r);
        t_coverage   c;
        int unsigned idx, srt;
        longint      sv, new_end, extent;
        bit          whole, bad;
        c = '0;
        c.status = ST_OK;
        if (r.req == REQ_DRAIN) begin
            if (pend > 0) begin
                idx = head % BUF_DEPTH;
                win_lo = (win_lo + 1) & 32'h7FFF_FFFF;
                c.position = win_lo[30:0];
                c.fwd = fwd_cnt[idx];
                c.rev = rev_cnt[idx];
                c.pos_valid = 1'b1;
                fwd_cnt[idx] = '0;
                rev_cnt[idx] = '0;
                head++;
                if (head >= BUF_DEPTH) begin
                    head = 0;
                    tail = (tail >= BUF_DEPTH) ? tail - BUF_DEPTH : 0;
                end
                cursor = head;
                pend--;
                if (pend == 0 && rebase_due) restart_ring();
            end
        end else if (pend > 0) begin
            c.status = ST_BUSY;
        end else if (r.req == REQ_BEGIN) begin
            sv = longint'($signed(r.start));
            drop_read();
            if (r.contig < cur_ctg || (r.contig == cur_ctg && sv < longint'(win_lo))) begin
                c.status = ST_ORDER;
            end else begin
                srt = (sv < 0) ? 0 : int'(sv);
                if (srt >= r.clen) begin
                    c.status = ST_IGNORED;
                end else begin
                    whole = (r.contig != cur_ctg) || (srt > win_hi);
                    pend = whole ? ((tail > head) ? tail - head : 0) : srt - win_lo;
                    seg_lo = srt;
                    seg_hi = srt;
                    strand = r.rev;
                    open_read = 1;
                    cursor = head;
                    if (whole) begin
                        cur_ctg = r.contig;
                        rebase_due = 1;
                        if (pend == 0) restart_ring();
                    end
                end
            end
        end else if (r.req == REQ_FLUSH) begin
            drop_read();
            seg_lo = (win_hi < 32'h7FFF_FFFF) ? win_hi + 1 : 32'h7FFF_FFFF;
            seg_hi = seg_lo;
            pend = (tail > head) ? tail - head : 0;
            rebase_due = 1;
            if (pend == 0) restart_ring();
        end else if (!open_read) begin
            c.status = ST_IGNORED;
        end else begin
            bad = 0;
            if (r.kind == OP_COVER || r.kind == OP_DEL) begin
                new_end = longint'(seg_hi) + longint'(r.len);
                extent = longint'(cursor - head) + (new_end - longint'(seg_lo));
                if (extent > BUF_DEPTH || new_end > longint'(POS_MAX)) begin
                    bad = 1;
                end else if (r.kind == OP_COVER) begin
                    seg_hi = int'(new_end);
                end else begin
                    paint_run();
                    cursor += r.len;
                    seg_lo = int'(new_end);
                    seg_hi = seg_lo;
                end
            end
            if (bad) begin
                c.status = ST_TOO_LONG;
                drop_read();
            end else if (r.last) begin
                paint_run();
                close_end();
                c.read_end = seg_hi[30:0];
                open_read = 0;
            end
        end
        c.pending = pend[12:0];
        return c;
    endfunction

    // queue a request and its predicted coverage result
    function automatic void push_request(t_request r);
        request_q.push_back(r);
        coverage_q.push_back(predict_coverage(r));
        n_total++;
    endfunction

    function automatic t_request mk(t_req q, int unsigned ctg, logic [31:0] st,
                                    int unsigned cl, bit rv, t_op k, int unsigned ln, bit lst);
        t_request r;
        r.req = q;
        r.contig = ctg[15:0];
        r.start = st;
        r.clen = cl[30:0];
        r.rev = rv;
        r.kind = k;
        r.len = ln[27:0];
        r.last = lst;
        return r;
    endfunction

    function automatic void drain_all();
        while (pend > 0) push_request(mk(REQ_DRAIN, 0, 0, 1, 0, OP_COVER, 0, 0));
    endfunction

    // a read on the current or next contig, mostly a short hop past the window start
    function automatic void random_read();
        int unsigned ctg, st, n_ops, ln;
        t_op         k;
        ctg = cur_ctg;
        if (win_lo > 32'h4000_0000 || $urandom_range(19) == 0)
            ctg = (cur_ctg < 16'hFFFF) ? cur_ctg + 1 : cur_ctg;
        st = (ctg != cur_ctg) ? $urandom_range(50) : win_lo + $urandom_range(30);
        if ($urandom_range(15) == 0) st = win_hi + 1 + $urandom_range(200);
        push_request(mk(REQ_BEGIN, ctg, st, ($urandom_range(30) == 0) ? st : st + 100000,
                        $urandom_range(1), OP_COVER, 0, 0));
        n_ops = $urandom_range(1, 5);
        for (int i = 0; i < n_ops; i++) begin
            case ($urandom_range(9))
                0, 1:    begin k = OP_DEL;  ln = $urandom_range(4); end
                2:       begin k = 2'($urandom_range(2, 3)); ln = $urandom; end
                default: begin k = OP_COVER; ln = $urandom_range(1, 40); end
            endcase
            if ($urandom_range(60) == 0) ln = $urandom_range(4096, 9000);
            push_request(mk(REQ_CIGAR, 0, 0, 1, 0, k, ln, i == n_ops - 1));
        end
    endfunction

    // ---------------------------------------------------------------
    // idling, driver and monitor
    // ---------------------------------------------------------------
    int send_idle, recv_idle;
    always_comb begin
        if (n_taken < n_total / 3) begin
            send_idle = 13;
            recv_idle = 78;
        end else if (n_taken < 2 * n_total / 3) begin
            send_idle = 78;
            recv_idle = 13;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    end

    // request driver, refilled when the current request is taken or none is held
    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) n_taken <= n_taken + 1;
            if (!s_valid || o_s_axis_tready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    r = request_q.pop_front();
                    s_data <= {4'b0, r.len, r.rev, r.clen, r.start, r.contig};
                    s_user <= {r.kind, r.req};
                    s_last <= r.last;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_coverage got, want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
            if (o_m_axis_tvalid && m_ready) begin
                got.status    = t_status'(o_m_axis_tuser[2:0]);
                got.pos_valid = o_m_axis_tuser[3];
                got.read_end  = o_m_axis_tdata[30:0];
                got.pending   = o_m_axis_tdata[43:31];
                got.position  = o_m_axis_tdata[74:44];
                got.fwd       = o_m_axis_tdata[98:75];
                got.rev       = o_m_axis_tdata[122:99];
                if (coverage_q.size() == 0) begin
                    $display("%0t unexpected result: actual %p", $time, got);
                    n_errors++;
                end else begin
                    want = coverage_q.pop_front();
                    if (got !== want) begin
                        $display("%0t result differs: expected %p actual %p",
                                 $time, want, got);
                        n_errors++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        int n_rand;
        for (int i = 0; i < BUF_DEPTH; i++) begin
            fwd_cnt[i] = '0;
            rev_cnt[i] = '0;
        end
        {head, tail, win_lo, win_hi, cur_ctg, cursor, seg_lo, seg_hi, pend} = '0;
        {rebase_due, strand, open_read} = '0;

        // nothing pending, flush of an empty ring, cigar without a read
        push_request(mk(REQ_DRAIN, 0, 0, 1, 0, OP_COVER, 0, 0));
        push_request(mk(REQ_FLUSH, 0, 0, 1, 0, OP_COVER, 0, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, 5, 1));
        // negative start clamps to zero, covering, deletion and a non-covering op
        push_request(mk(REQ_BEGIN, 0, -5, 100, 0, OP_COVER, 0, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, 10, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_DEL, 3, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, 2'd3, 28'hFFF_FFFF, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, 5, 1));
        // reverse read retires earlier positions, busy answer while draining
        push_request(mk(REQ_BEGIN, 0, 4, 100, 1, OP_COVER, 0, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, 20, 1));
        drain_all();
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, 20, 1));
        // start below the last one, start past the contig end
        push_request(mk(REQ_BEGIN, 0, 2, 100, 0, OP_COVER, 0, 0));
        push_request(mk(REQ_BEGIN, 0, 200, 100, 0, OP_COVER, 0, 0));
        // too long by length and by extent
        push_request(mk(REQ_BEGIN, 0, 10, 1000, 0, OP_COVER, 0, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, 28'hFFF_FFFF, 0));
        drain_all();
        push_request(mk(REQ_BEGIN, 0, 12, 1000, 1, OP_COVER, 0, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, BUF_DEPTH + 1, 0));
        drain_all();
        push_request(mk(REQ_FLUSH, 0, 0, 1, 0, OP_COVER, 0, 0));
        drain_all();
        // read ending at the top of the coordinate range, flush saturates
        push_request(mk(REQ_BEGIN, 1, 32'h7FFF_FFFC, 32'h7FFF_FFFF, 0, OP_COVER, 0, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, 3, 1));
        push_request(mk(REQ_FLUSH, 0, 0, 1, 0, OP_COVER, 0, 0));
        drain_all();
        push_request(mk(REQ_BEGIN, 1, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 1, OP_COVER, 0, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, 1, 1));
        push_request(mk(REQ_FLUSH, 0, 0, 1, 0, OP_COVER, 0, 0));
        drain_all();

        // random part: mostly well-formed reads with drains, some noise
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            n_rand -= n_total;
            if (pend > 0) begin
                if ($urandom_range(7) == 0)
                    push_request(mk(t_req'($urandom_range(3)), 0, 0, 1, 0, OP_COVER, 0, 1));
                drain_all();
            end
            case ($urandom_range(19))
                0: push_request(mk(REQ_FLUSH, 0, 0, 1, 0, OP_COVER, 0, 0));
                1: push_request(mk(t_req'($urandom_range(3)), $urandom, $urandom,
                                   $urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1),
                                   2'($urandom), $urandom, $urandom_range(1)));
                2: push_request(mk(REQ_BEGIN, cur_ctg, win_lo - $urandom_range(1, 3),
                                   32'h7FFF_FFFF, 0, OP_COVER, 0, 0));
                default: random_read();
            endcase
            n_rand += n_total;
        end
        drain_all();

        // a read filling the whole buffer, left pending at the end
        push_request(mk(REQ_BEGIN, cur_ctg, win_lo, 32'h7FFF_FFFF, 0, OP_COVER, 0, 0));
        push_request(mk(REQ_CIGAR, 0, 0, 1, 0, OP_COVER, BUF_DEPTH, 1));
        push_request(mk(REQ_FLUSH, 0, 0, 1, 0, OP_COVER, 0, 0));

        @(posedge i_clk);
        @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (request_q.size() != 0 || s_valid || coverage_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
